FILE: rtl/assert_macros.svh
// Assertion macros for the k-way merge RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KWM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KWM_ASSERT(label, prop, msg)
`define KWM_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: rtl/kwm_pkg.sv
// Shared constants, types and helpers for the k-way merge block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 8;
  localparam int STORE_SIZE = NUM_LISTS * LIST_DEPTH;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 3;
  localparam int VAL_W  = 32;
  localparam int ADDR_W = $clog2(STORE_SIZE);
  localparam int LIST_W = $clog2(NUM_LISTS);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int REM_W  = $clog2(STORE_SIZE + 1);
  localparam int SCAN_W = $clog2(NUM_LISTS + 1);

  localparam logic [CMD_W-1:0] CMD_LOAD       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE      = 2'd2;

  typedef logic signed [VAL_W-1:0] elem_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [LIST_W-1:0]       list_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    elem_t data;
  } wr_req_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  function automatic addr_t elem_addr(input list_t lst, input cnt_t ptr);
    elem_addr = ADDR_W'(ADDR_W'(lst) * ADDR_W'(LIST_DEPTH) + ADDR_W'(ptr));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kwm_store.sv
// Element store: one write port, one registered read port.
// Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_store (
  input  wire logic             clk,
  input  wire kwm_pkg::wr_req_t wr,
  input  wire kwm_pkg::rd_req_t rd,
  output kwm_pkg::elem_t        rd_data
);

  kwm_pkg::elem_t mem [kwm_pkg::STORE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/k_way_sorted_merge.sv
// k-way merge top level: list loading, head scan and result register.
// Depends on kwm_pkg, kwm_store and assert_macros.svh.
//
//   channel | direction | fields                                  | handshake
//   in      | input     | command, list_id, value                 | in_valid / in_ready
//   out     | output    | merged_value, is_last, empty_set,       | out_valid / out_ready
//           |           | overflowed                              |
//
// Loads are taken back to back while no close runs. A close scans the list
// heads through the single store read port for each result, empty set
// included. The result register frees the scan to start on the next result
// while the previous one waits. No input is taken during a close; after the
// last result is registered, loading resumes at once.
// Synchronous reset clears all list pointers; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module k_way_sorted_merge (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [kwm_pkg::CMD_W-1:0]    command,
  input  wire logic [kwm_pkg::ID_W-1:0]     list_id,
  input  wire logic signed [kwm_pkg::VAL_W-1:0] value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [kwm_pkg::VAL_W-1:0]  merged_value,
  output logic                              is_last,
  output logic                              empty_set,
  output logic                              overflowed
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;

  kwm_pkg::cnt_t  count [kwm_pkg::NUM_LISTS];
  kwm_pkg::cnt_t  head  [kwm_pkg::NUM_LISTS];
  logic           ovf_seen;
  logic [kwm_pkg::REM_W-1:0]  remaining;
  logic [kwm_pkg::SCAN_W-1:0] scan_cnt;

  logic           rd_en;
  kwm_pkg::list_t rd_list;
  logic           rd_hit;
  logic           rd_last;
  kwm_pkg::elem_t rd_data;

  logic           best_found;
  kwm_pkg::elem_t best_val;
  kwm_pkg::list_t best_list;

  kwm_pkg::wr_req_t wr_req;
  kwm_pkg::rd_req_t rd_req;

  logic           in_xfer;
  logic           has_elem;
  logic           closes;
  logic           id_ok;
  kwm_pkg::list_t id_idx;
  logic           room;
  kwm_pkg::list_t scan_idx;
  logic           take;
  logic           emit;
  logic           emit_last;
  logic           heads_ok;

  assign in_ready = (state == S_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign has_elem = (command == kwm_pkg::CMD_LOAD) || (command == kwm_pkg::CMD_LOAD_CLOSE);
  assign closes   = (command == kwm_pkg::CMD_LOAD_CLOSE) || (command == kwm_pkg::CMD_CLOSE);
  assign id_ok    = 32'(list_id) < 32'(kwm_pkg::NUM_LISTS);
  assign id_idx   = kwm_pkg::LIST_W'(list_id);
  assign room     = count[id_idx] < kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH);
  assign scan_idx = scan_cnt[kwm_pkg::LIST_W-1:0];

  always_comb begin
    wr_req.en   = in_xfer && has_elem && id_ok && room;
    wr_req.addr = kwm_pkg::elem_addr(id_idx, count[id_idx]);
    wr_req.data = value;
    rd_req.en   = (state == S_SCAN) && (scan_cnt < kwm_pkg::SCAN_W'(kwm_pkg::NUM_LISTS));
    rd_req.addr = kwm_pkg::elem_addr(scan_idx, head[scan_idx]);
  end

  // strict compare keeps the lower list on ties
  assign take      = rd_en && rd_hit && (!best_found || (rd_data < best_val));
  assign emit      = (state == S_FIN) && (!out_valid || out_ready);
  assign emit_last = !best_found || (remaining == kwm_pkg::REM_W'(1));

  always_comb begin
    heads_ok = 1'b1;
    for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
      heads_ok = heads_ok && (head[i] <= count[i]);
    end
  end

  kwm_store u_store (
    .clk     (clk),
    .wr      (wr_req),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      ovf_seen   <= 1'b0;
      remaining  <= '0;
      scan_cnt   <= '0;
      rd_en      <= 1'b0;
      best_found <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
      end
    end else begin
      rd_en <= rd_req.en;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (has_elem && id_ok) begin
              if (room) begin
                count[id_idx] <= count[id_idx] + kwm_pkg::CNT_W'(1);
                remaining     <= remaining + kwm_pkg::REM_W'(1);
              end else begin
                ovf_seen <= 1'b1;
              end
            end
            if (closes) begin
              state      <= S_SCAN;
              scan_cnt   <= '0;
              best_found <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (rd_req.en) begin
            scan_cnt <= scan_cnt + kwm_pkg::SCAN_W'(1);
          end
          if (take) begin
            best_found <= 1'b1;
          end
          if (rd_en && rd_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (emit) begin
            if (emit_last) begin
              state     <= S_LOAD;
              ovf_seen  <= 1'b0;
              remaining <= '0;
              for (int i = 0; i < kwm_pkg::NUM_LISTS; i++) begin
                count[i] <= '0;
                head[i]  <= '0;
              end
            end else begin
              head[best_list] <= head[best_list] + kwm_pkg::CNT_W'(1);
              remaining       <= remaining - kwm_pkg::REM_W'(1);
              state           <= S_SCAN;
              scan_cnt        <= '0;
              best_found      <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_list <= scan_idx;
    rd_hit  <= head[scan_idx] < count[scan_idx];
    rd_last <= scan_idx == kwm_pkg::LIST_W'(kwm_pkg::NUM_LISTS - 1);
    if (take) begin
      best_val  <= rd_data;
      best_list <= rd_list;
    end
    if (emit) begin
      overflowed <= ovf_seen;
      is_last    <= emit_last;
      if (best_found) begin
        merged_value <= best_val;
        empty_set    <= 1'b0;
      end else begin
        merged_value <= '0;
        empty_set    <= 1'b1;
      end
    end
  end

  `KWM_ASSERT_RST(a_rst_idle, rst |=> (!out_valid && in_ready), "not idle after reset")
  `KWM_ASSERT(a_fin_match, (state == S_FIN) |-> (best_found == (remaining != '0)), "scan missed an element")
  `KWM_ASSERT(a_rem_bound, remaining <= kwm_pkg::REM_W'(kwm_pkg::STORE_SIZE), "element count too large")
  `KWM_ASSERT(a_heads_ok, heads_ok, "read pointer past fill count")
  `KWM_ASSERT(a_rd_scan, rd_en |-> (state == S_SCAN), "store read outside scan")

endmodule

`default_nettype wire
